// File: src/csbs_pkg.sv
`default_nettype none

package csbs_pkg;

   // region size limit
   localparam int MAX_BYTES_DEFAULT = 65536;

   // field widths
   localparam int BYTE_WIDTH  = 8;
   localparam int CODE_WIDTH  = 18;
   localparam int NOP_WIDTH   = 17;
   localparam int SHELL_WIDTH = 20;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 20;
   localparam int WINDOW_DEPTH    = 8;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PATTERN_ENABLE  = 4'd0,
      CSR_CODE_THRESHOLD  = 4'd1,
      CSR_NOP_THRESHOLD   = 4'd2,
      CSR_SHELL_THRESHOLD = 4'd3
   } csr_index_type;

   // register reset values
   localparam logic                   PATTERN_ENABLE_RESET  = 1'b1;
   localparam logic [CODE_WIDTH-1:0]  CODE_THRESHOLD_RESET  = 18'd10;
   localparam logic [NOP_WIDTH-1:0]   NOP_THRESHOLD_RESET   = 17'd32;
   localparam logic [SHELL_WIDTH-1:0] SHELL_THRESHOLD_RESET = 20'd10;

   // byte patterns
   localparam logic [7:0] NOP_BYTE      = 8'h90;
   localparam logic [7:0] PUSH_EBP      = 8'h55;
   localparam logic [7:0] MOV_OPCODE    = 8'h8B;
   localparam logic [7:0] MOV_EBP_ESP   = 8'hEC;
   localparam logic [7:0] CALL_NEAR     = 8'hE8;
   localparam logic [7:0] CALL_INDIRECT = 8'hFF;
   localparam logic [7:0] TWO_BYTE_ESC  = 8'h0F;
   localparam logic [7:0] SYSCALL_LO    = 8'h05;
   localparam logic [7:0] SYSENTER_LO   = 8'h34;
   localparam logic [7:0] FS_PREFIX     = 8'h64;
   localparam logic [7:0] MOV_EAX_MOFFS = 8'hA1;
   localparam logic [7:0] PEB_OFFSET    = 8'h30;
   localparam logic [7:0] ZERO_BYTE     = 8'h00;
   localparam logic [31:0] HASH_A       = 32'hEC0E4E8E;
   localparam logic [31:0] HASH_B       = 32'h7C0DFCAA;

   // score increments
   localparam logic [2:0] CODE_PROLOGUE_ADD = 3'd1;
   localparam logic [2:0] CODE_CALL_ADD     = 3'd1;
   localparam logic [2:0] CODE_SYSCALL_ADD  = 3'd3;
   localparam logic [4:0] SHELL_PEB_ADD     = 5'd5;
   localparam logic [4:0] SHELL_HASH_ADD    = 5'd10;

endpackage

`default_nettype wire

// File: src/code_signature_byte_scanner.sv
// Result: the result word is registered and valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the per-byte window compares and counter updates settle
// combinationally between the window/score registers. A last byte is held off only
// while the previous result word still sits untaken in the output register.
// Reset: synchronous, active high; clears scores, position and result valid, and
// restores the configuration registers to their defaults.
`default_nettype none

module code_signature_byte_scanner #(
   parameter int MAX_BYTES = csbs_pkg::MAX_BYTES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // byte input channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [csbs_pkg::BYTE_WIDTH-1:0]     req_data_byte,
   input  wire logic                                req_last_byte,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_has_code,
   output logic                                     rsp_has_nop_sled,
   output logic                                     rsp_has_shellcode,
   output logic [csbs_pkg::CODE_WIDTH-1:0]          rsp_code_score,
   output logic [csbs_pkg::NOP_WIDTH-1:0]           rsp_longest_nop_run,
   output logic [csbs_pkg::SHELL_WIDTH-1:0]         rsp_shell_score,
   // configuration write port
   input  wire logic                                csr_write_enable,
   input  wire logic [csbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [csbs_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);

   localparam int POS_W   = $clog2(MAX_BYTES + 1);
   localparam int CODE_W  = csbs_pkg::CODE_WIDTH;
   localparam int NOP_W   = csbs_pkg::NOP_WIDTH;
   localparam int SHELL_W = csbs_pkg::SHELL_WIDTH;

   // configuration registers
   logic               pattern_enable_ff;
   logic [CODE_W-1:0]  code_threshold_ff;
   logic [NOP_W-1:0]   nop_threshold_ff;
   logic [SHELL_W-1:0] shell_threshold_ff;

   // scan state
   logic [7:0]         byte_window_ff [csbs_pkg::WINDOW_DEPTH];
   logic [POS_W-1:0]   byte_position_ff;
   logic [CODE_W-1:0]  code_total_ff,   code_total_in;
   logic [NOP_W-1:0]   nop_run_now_ff,  nop_run_now_in;
   logic [NOP_W-1:0]   nop_run_best_ff, nop_run_best_in;
   logic [SHELL_W-1:0] shell_total_ff,  shell_total_in;

   // result register
   logic               rsp_valid_ff;
   logic               has_code_ff, has_nop_sled_ff, has_shellcode_ff;
   logic [CODE_W-1:0]  code_score_ff;
   logic [NOP_W-1:0]   longest_nop_run_ff;
   logic [SHELL_W-1:0] shell_score_ff;

   logic               req_accept;
   logic               take_byte;
   logic [2:0]         code_add;
   logic [4:0]         shell_add;
   logic [CODE_W:0]    code_sum;
   logic [SHELL_W:0]   shell_sum;
   logic [NOP_W:0]     nop_sum;
   logic [31:0]        hash_word;

   // a last byte waits only while an untaken result sits in the output register
   assign req_ready  = !rsp_valid_ff || rsp_ready || !req_last_byte;
   assign req_accept = req_valid && req_ready;
   assign take_byte  = req_accept && (byte_position_ff < POS_W'(MAX_BYTES));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_enable_ff  <= csbs_pkg::PATTERN_ENABLE_RESET;
         code_threshold_ff  <= csbs_pkg::CODE_THRESHOLD_RESET;
         nop_threshold_ff   <= csbs_pkg::NOP_THRESHOLD_RESET;
         shell_threshold_ff <= csbs_pkg::SHELL_THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            csbs_pkg::CSR_PATTERN_ENABLE:  pattern_enable_ff  <= csr_write_data[0];
            csbs_pkg::CSR_CODE_THRESHOLD:  code_threshold_ff  <= csr_write_data[CODE_W-1:0];
            csbs_pkg::CSR_NOP_THRESHOLD:   nop_threshold_ff   <= csr_write_data[NOP_W-1:0];
            csbs_pkg::CSR_SHELL_THRESHOLD: shell_threshold_ff <= csr_write_data[SHELL_W-1:0];
            default: ;
         endcase
      end
   end

   // pattern checks on the window and saturating score updates
   always_comb begin
      code_add = 3'd0;
      if (byte_window_ff[3] == csbs_pkg::PUSH_EBP && byte_window_ff[2] == csbs_pkg::MOV_OPCODE
          && byte_window_ff[1] == csbs_pkg::MOV_EBP_ESP) begin
         code_add = code_add + csbs_pkg::CODE_PROLOGUE_ADD;
      end
      if (byte_window_ff[3] == csbs_pkg::CALL_NEAR
          || byte_window_ff[3] == csbs_pkg::CALL_INDIRECT) begin
         code_add = code_add + csbs_pkg::CODE_CALL_ADD;
      end
      if (byte_window_ff[3] == csbs_pkg::TWO_BYTE_ESC
          && (byte_window_ff[2] == csbs_pkg::SYSCALL_LO
              || byte_window_ff[2] == csbs_pkg::SYSENTER_LO)) begin
         code_add = code_add + csbs_pkg::CODE_SYSCALL_ADD;
      end

      hash_word = {byte_window_ff[4], byte_window_ff[5], byte_window_ff[6], byte_window_ff[7]};
      shell_add = 5'd0;
      if (byte_window_ff[7] == csbs_pkg::FS_PREFIX && byte_window_ff[6] == csbs_pkg::MOV_EAX_MOFFS
          && byte_window_ff[5] == csbs_pkg::PEB_OFFSET
          && byte_window_ff[4] == csbs_pkg::ZERO_BYTE) begin
         shell_add = shell_add + csbs_pkg::SHELL_PEB_ADD;
      end
      if (hash_word == csbs_pkg::HASH_A || hash_word == csbs_pkg::HASH_B) begin
         shell_add = shell_add + csbs_pkg::SHELL_HASH_ADD;
      end

      code_sum  = {1'b0, code_total_ff} + (CODE_W + 1)'(code_add);
      shell_sum = {1'b0, shell_total_ff} + (SHELL_W + 1)'(shell_add);
      nop_sum   = {1'b0, nop_run_now_ff} + (NOP_W + 1)'(1);

      code_total_in   = code_total_ff;
      shell_total_in  = shell_total_ff;
      nop_run_now_in  = nop_run_now_ff;
      nop_run_best_in = nop_run_best_ff;

      if (take_byte) begin
         // a start position counts once enough bytes have followed it
         if (byte_position_ff >= POS_W'(4)) begin
            code_total_in = code_sum[CODE_W] ? '1 : code_sum[CODE_W-1:0];
         end
         if (byte_position_ff >= POS_W'(8)) begin
            shell_total_in = shell_sum[SHELL_W] ? '1 : shell_sum[SHELL_W-1:0];
         end
         if (req_data_byte == csbs_pkg::NOP_BYTE) begin
            nop_run_now_in = nop_sum[NOP_W] ? '1 : nop_sum[NOP_W-1:0];
            if (nop_run_now_in > nop_run_best_ff) begin
               nop_run_best_in = nop_run_now_in;
            end
         end else begin
            nop_run_now_in = '0;
         end
      end
   end

   // byte window shift line
   always_ff @(posedge clock) begin
      if (take_byte) begin
         byte_window_ff[0] <= req_data_byte;
         for (int k = 1; k < csbs_pkg::WINDOW_DEPTH; k++) begin
            byte_window_ff[k] <= byte_window_ff[k-1];
         end
      end
   end

   // scan state: updated per byte, cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         code_total_ff    <= '0;
         nop_run_now_ff   <= '0;
         nop_run_best_ff  <= '0;
         shell_total_ff   <= '0;
      end else if (req_accept && req_last_byte) begin
         byte_position_ff <= '0;
         code_total_ff    <= '0;
         nop_run_now_ff   <= '0;
         nop_run_best_ff  <= '0;
         shell_total_ff   <= '0;
      end else begin
         if (take_byte) begin
            byte_position_ff <= byte_position_ff + POS_W'(1);
         end
         code_total_ff   <= code_total_in;
         nop_run_now_ff  <= nop_run_now_in;
         nop_run_best_ff <= nop_run_best_in;
         shell_total_ff  <= shell_total_in;
      end
   end

   // result word valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && req_last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result word payload
   always_ff @(posedge clock) begin
      if (req_accept && req_last_byte) begin
         has_code_ff        <= pattern_enable_ff && (code_total_in > code_threshold_ff);
         has_nop_sled_ff    <= pattern_enable_ff && (nop_run_best_in > nop_threshold_ff);
         has_shellcode_ff   <= pattern_enable_ff && (shell_total_in > shell_threshold_ff);
         code_score_ff      <= code_total_in;
         longest_nop_run_ff <= nop_run_best_in;
         shell_score_ff     <= shell_total_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_has_code        = has_code_ff;
   assign rsp_has_nop_sled    = has_nop_sled_ff;
   assign rsp_has_shellcode   = has_shellcode_ff;
   assign rsp_code_score      = code_score_ff;
   assign rsp_longest_nop_run = longest_nop_run_ff;
   assign rsp_shell_score     = shell_score_ff;

endmodule

`default_nettype wire
